@@ sv/jmsp_pkg.sv @@
package jmsp_pkg;

    localparam int MaxRes = 4;

    localparam logic [7:0] M_SOI  = 8'hD8;
    localparam logic [7:0] M_EOI  = 8'hD9;
    localparam logic [7:0] M_DRI  = 8'hDD;
    localparam logic [7:0] M_SOF0 = 8'hC0;
    localparam logic [7:0] M_SOF2 = 8'hC2;
    localparam logic [7:0] M_DQT  = 8'hDB;
    localparam logic [7:0] M_DHT  = 8'hC4;
    localparam logic [7:0] M_SOS  = 8'hDA;
    localparam logic [7:0] M_RST0 = 8'hD0;
    localparam logic [7:0] M_RST7 = 8'hD7;
    localparam logic [7:0] M_TEM  = 8'h01;
    localparam logic [7:0] FILL_B = 8'hFF;

    localparam logic [3:0] EV_MARKER  = 4'd0;
    localparam logic [3:0] EV_FRAME   = 4'd1;
    localparam logic [3:0] EV_QUANT   = 4'd2;
    localparam logic [3:0] EV_HCOUNT  = 4'd3;
    localparam logic [3:0] EV_HSYM    = 4'd4;
    localparam logic [3:0] EV_SCANF   = 4'd5;
    localparam logic [3:0] EV_RESTART = 4'd6;
    localparam logic [3:0] EV_SBYTE   = 4'd7;
    localparam logic [3:0] EV_ERROR   = 4'd8;
    localparam logic [3:0] EV_END     = 4'd9;

    localparam logic [15:0] ERR_NOT_SOI = 16'd0;
    localparam logic [15:0] ERR_PROG    = 16'd1;
    localparam logic [15:0] ERR_NCOMP   = 16'd2;

    localparam logic [4:0] PH_FIRST = 5'd0;
    localparam logic [4:0] PH_HUNT = 5'd1;
    localparam logic [4:0] PH_THUMB = 5'd2;
    localparam logic [4:0] PH_SCAN = 5'd3;
    localparam logic [4:0] PH_LEN_HI = 5'd4;
    localparam logic [4:0] PH_LEN_LO = 5'd5;
    localparam logic [4:0] PH_SKIP = 5'd6;
    localparam logic [4:0] PH_DRI_HI = 5'd7;
    localparam logic [4:0] PH_DRI_LO = 5'd8;
    localparam logic [4:0] PH_SOF_P = 5'd9;
    localparam logic [4:0] PH_SOF_H1 = 5'd10;
    localparam logic [4:0] PH_SOF_H2 = 5'd11;
    localparam logic [4:0] PH_SOF_W1 = 5'd12;
    localparam logic [4:0] PH_SOF_W2 = 5'd13;
    localparam logic [4:0] PH_SOF_N = 5'd14;
    localparam logic [4:0] PH_SOF_CID = 5'd15;
    localparam logic [4:0] PH_SOF_CS = 5'd16;
    localparam logic [4:0] PH_SOF_CQ = 5'd17;
    localparam logic [4:0] PH_DQT_HDR = 5'd18;
    localparam logic [4:0] PH_DQT_E8 = 5'd19;
    localparam logic [4:0] PH_DQT_EH = 5'd20;
    localparam logic [4:0] PH_DQT_EL = 5'd21;
    localparam logic [4:0] PH_DHT_HDR = 5'd22;
    localparam logic [4:0] PH_DHT_CNT = 5'd23;
    localparam logic [4:0] PH_DHT_SYM = 5'd24;
    localparam logic [4:0] PH_SOS_NS = 5'd25;
    localparam logic [4:0] PH_SOS_SEL = 5'd26;
    localparam logic [4:0] PH_SOS_TAB = 5'd27;
    localparam logic [4:0] PH_SOS_SS = 5'd28;
    localparam logic [4:0] PH_SOS_SE = 5'd29;
    localparam logic [4:0] PH_SOS_A = 5'd30;
    localparam logic [4:0] PH_SOS_TAIL = 5'd31;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  slot;
        logic [7:0]  idx;
        logic [15:0] value;
    } event_t;

    typedef struct packed {
        logic [2:0]               count;
        event_t [MaxRes-1:0]      ev;
    } batch_t;

    function automatic event_t mk_ev(logic [3:0] k, logic [1:0] s, logic [7:0] i,
                                     logic [15:0] v);
        event_t e;
        e.kind = k;
        e.slot = s;
        e.idx = i;
        e.value = v;
        return e;
    endfunction

endpackage

@@ sv/jmsp_core.sv @@
module jmsp_core
    import jmsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output batch_t     batch
);

    logic [4:0]  phase_reg, phase_next;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  fpos_reg, fpos_next;
    logic [7:0]  hold_reg, hold_next;
    logic [1:0]  table_reg, table_next;
    logic [11:0] symtot_reg, symtot_next;
    logic [15:0] restart_reg, restart_next;
    logic [7:0]  ncomp_reg, ncomp_next;
    logic [3:0]  maxh_reg, maxh_next;
    logic [3:0]  maxv_reg, maxv_next;
    logic        pff_reg, pff_next;
    logic        halted_reg, halted_next;

    always_comb begin
        logic [2:0]  n;
        logic [15:0] w;
        logic [15:0] len;
        logic [4:0]  tgt;
        logic        mk;
        logic        dispatch;
        logic        in_sos;
        logic [7:0]  fp1;
        logic [11:0] st;
        logic [3:0]  h;
        logic [3:0]  v;
        phase_next = phase_reg;
        remain_next = remain_reg;
        fpos_next = fpos_reg;
        hold_next = hold_reg;
        table_next = table_reg;
        symtot_next = symtot_reg;
        restart_next = restart_reg;
        ncomp_next = ncomp_reg;
        maxh_next = maxh_reg;
        maxv_next = maxv_reg;
        pff_next = pff_reg;
        halted_next = halted_reg;
        batch.ev = '0;
        n = 3'd0;
        w = {hold_reg, data_byte};
        mk = 1'b0;
        dispatch = 1'b0;
        in_sos = phase_reg >= PH_SOS_NS;
        fp1 = fpos_reg + 8'd1;
        len = 16'd0;
        tgt = PH_SKIP;
        st = 12'd0;
        h = data_byte[7:4];
        v = data_byte[3:0];

        // marker search shared by the hunting phases
        if (pff_reg) begin
            if (data_byte != FILL_B) begin
                pff_next = 1'b0;
                mk = data_byte != 8'h00;
            end
        end else if (data_byte == FILL_B) begin
            pff_next = 1'b1;
        end

        if (!halted_reg) begin
            case (phase_reg)
                PH_FIRST: begin
                    if (mk) begin
                        batch.ev[0] = mk_ev(EV_MARKER, 2'd0, 8'd0, {8'd0, data_byte});
                        n = 3'd1;
                        if (data_byte == M_SOI) begin
                            phase_next = PH_HUNT;
                        end else begin
                            batch.ev[1] = mk_ev(EV_ERROR, 2'd0, 8'd0, ERR_NOT_SOI);
                            n = 3'd2;
                            halted_next = 1'b1;
                        end
                    end
                end
                PH_HUNT: begin
                    dispatch = mk;
                end
                PH_THUMB: begin
                    if (mk && data_byte == M_EOI) phase_next = PH_HUNT;
                end
                PH_SCAN: begin
                    pff_next = pff_reg;
                    if (!pff_reg) begin
                        if (data_byte == FILL_B) begin
                            pff_next = 1'b1;
                        end else begin
                            batch.ev[0] = mk_ev(EV_SBYTE, 2'd0, 8'd0, {8'd0, data_byte});
                            n = 3'd1;
                        end
                    end else if (data_byte != FILL_B) begin
                        pff_next = 1'b0;
                        if (data_byte == 8'h00) begin
                            batch.ev[0] = mk_ev(EV_SBYTE, 2'd0, 8'd0, {8'd0, FILL_B});
                            batch.ev[1] = mk_ev(EV_SBYTE, 2'd0, 8'd0, 16'd0);
                            n = 3'd2;
                        end else if (restart_reg != 16'd0 && data_byte >= M_RST0 &&
                                     data_byte <= M_RST7) begin
                            batch.ev[0] = mk_ev(EV_RESTART, 2'd0, 8'd1, {8'd0, data_byte});
                            n = 3'd1;
                        end else begin
                            dispatch = 1'b1;
                        end
                    end
                end
                PH_LEN_HI: begin
                    pff_next = pff_reg;
                    hold_next = data_byte;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    pff_next = pff_reg;
                    len = w;
                    tgt = fpos_reg[4:0];
                    remain_next = (len >= 16'd2) ? len - 16'd2 : 16'd0;
                    fpos_next = 8'd0;
                    if (tgt < PH_SKIP) tgt = PH_SKIP;
                    if (remain_next == 16'd0)
                        phase_next = (tgt >= PH_SOS_NS) ? PH_SCAN : PH_HUNT;
                    else
                        phase_next = tgt;
                end
                default: begin
                    pff_next = pff_reg;
                    remain_next = remain_reg - 16'd1;
                    case (phase_reg)
                        PH_DRI_HI: begin
                            hold_next = data_byte;
                            phase_next = PH_DRI_LO;
                        end
                        PH_DRI_LO: begin
                            restart_next = w;
                            batch.ev[0] = mk_ev(EV_RESTART, 2'd0, 8'd0, w);
                            n = 3'd1;
                            phase_next = PH_SKIP;
                        end
                        PH_SOF_P: begin
                            batch.ev[0] = mk_ev(EV_FRAME, 2'd0, 8'd0, {8'd0, data_byte});
                            n = 3'd1;
                            phase_next = PH_SOF_H1;
                        end
                        PH_SOF_H1: begin
                            hold_next = data_byte;
                            phase_next = PH_SOF_H2;
                        end
                        PH_SOF_H2: begin
                            batch.ev[0] = mk_ev(EV_FRAME, 2'd0, 8'd1, w);
                            n = 3'd1;
                            phase_next = PH_SOF_W1;
                        end
                        PH_SOF_W1: begin
                            hold_next = data_byte;
                            phase_next = PH_SOF_W2;
                        end
                        PH_SOF_W2: begin
                            batch.ev[0] = mk_ev(EV_FRAME, 2'd0, 8'd2, w);
                            n = 3'd1;
                            phase_next = PH_SOF_N;
                        end
                        PH_SOF_N: begin
                            ncomp_next = data_byte;
                            batch.ev[0] = mk_ev(EV_FRAME, 2'd0, 8'd3, {8'd0, data_byte});
                            n = 3'd1;
                            if (data_byte != 8'd3) begin
                                batch.ev[1] = mk_ev(EV_ERROR, 2'd0, 8'd0, ERR_NCOMP);
                                n = 3'd2;
                                halted_next = 1'b1;
                            end else begin
                                fpos_next = 8'd0;
                                phase_next = PH_SOF_CID;
                            end
                        end
                        PH_SOF_CID: begin
                            batch.ev[0] = mk_ev(EV_FRAME, fpos_reg[1:0], 8'd4,
                                                {8'd0, data_byte});
                            n = 3'd1;
                            phase_next = PH_SOF_CS;
                        end
                        PH_SOF_CS: begin
                            if (h > maxh_reg) maxh_next = h;
                            if (v > maxv_reg) maxv_next = v;
                            batch.ev[0] = mk_ev(EV_FRAME, fpos_reg[1:0], 8'd5,
                                                {8'd0, data_byte});
                            n = 3'd1;
                            phase_next = PH_SOF_CQ;
                        end
                        PH_SOF_CQ: begin
                            batch.ev[0] = mk_ev(EV_FRAME, fpos_reg[1:0], 8'd6,
                                                {8'd0, data_byte});
                            n = 3'd1;
                            fpos_next = fp1;
                            if (fp1 >= 8'd3) begin
                                batch.ev[1] = mk_ev(EV_FRAME, 2'd0, 8'd7, {12'd0, maxh_reg});
                                batch.ev[2] = mk_ev(EV_FRAME, 2'd0, 8'd8, {12'd0, maxv_reg});
                                n = 3'd3;
                                phase_next = PH_SKIP;
                            end else begin
                                phase_next = PH_SOF_CID;
                            end
                        end
                        PH_DQT_HDR: begin
                            table_next = data_byte[1:0];
                            fpos_next = 8'd0;
                            phase_next = (data_byte[7:4] != 4'd0) ? PH_DQT_EH : PH_DQT_E8;
                        end
                        PH_DQT_EH: begin
                            hold_next = data_byte;
                            phase_next = PH_DQT_EL;
                        end
                        PH_DQT_E8, PH_DQT_EL: begin
                            batch.ev[0] = mk_ev(EV_QUANT, table_reg, fpos_reg,
                                (phase_reg == PH_DQT_E8) ? {8'd0, data_byte} : w);
                            n = 3'd1;
                            fpos_next = fp1;
                            if (fp1 >= 8'd64) phase_next = PH_DQT_HDR;
                            else if (phase_reg == PH_DQT_EL) phase_next = PH_DQT_EH;
                        end
                        PH_DHT_HDR: begin
                            // class*2 + id, kept to two bits
                            table_next = {data_byte[4], 1'b0} + data_byte[1:0];
                            fpos_next = 8'd0;
                            symtot_next = 12'd0;
                            phase_next = PH_DHT_CNT;
                        end
                        PH_DHT_CNT: begin
                            batch.ev[0] = mk_ev(EV_HCOUNT, table_reg, fpos_reg,
                                                {8'd0, data_byte});
                            n = 3'd1;
                            st = symtot_reg + {4'd0, data_byte};
                            symtot_next = st;
                            fpos_next = fp1;
                            if (fp1 >= 8'd16) begin
                                fpos_next = 8'd0;
                                phase_next = (st != 12'd0) ? PH_DHT_SYM : PH_DHT_HDR;
                            end
                        end
                        PH_DHT_SYM: begin
                            batch.ev[0] = mk_ev(EV_HSYM, table_reg, fpos_reg,
                                                {8'd0, data_byte});
                            n = 3'd1;
                            fpos_next = fp1;
                            symtot_next = symtot_reg - 12'd1;
                            if (symtot_next == 12'd0) phase_next = PH_DHT_HDR;
                        end
                        PH_SOS_NS: begin
                            ncomp_next = data_byte;
                            batch.ev[0] = mk_ev(EV_SCANF, 2'd0, 8'd0, {8'd0, data_byte});
                            n = 3'd1;
                            fpos_next = 8'd0;
                            phase_next = (data_byte != 8'd0) ? PH_SOS_SEL : PH_SOS_SS;
                        end
                        PH_SOS_SEL: begin
                            batch.ev[0] = mk_ev(EV_SCANF, fpos_reg[1:0], 8'd1,
                                                {8'd0, data_byte});
                            n = 3'd1;
                            phase_next = PH_SOS_TAB;
                        end
                        PH_SOS_TAB: begin
                            batch.ev[0] = mk_ev(EV_SCANF, fpos_reg[1:0], 8'd2,
                                                {8'd0, data_byte});
                            n = 3'd1;
                            fpos_next = fp1;
                            phase_next = (fp1 >= ncomp_reg) ? PH_SOS_SS : PH_SOS_SEL;
                        end
                        PH_SOS_SS: begin
                            batch.ev[0] = mk_ev(EV_SCANF, 2'd0, 8'd3, {8'd0, data_byte});
                            n = 3'd1;
                            phase_next = PH_SOS_SE;
                        end
                        PH_SOS_SE: begin
                            batch.ev[0] = mk_ev(EV_SCANF, 2'd0, 8'd4, {8'd0, data_byte});
                            n = 3'd1;
                            phase_next = PH_SOS_A;
                        end
                        PH_SOS_A: begin
                            batch.ev[0] = mk_ev(EV_SCANF, 2'd0, 8'd5, {8'd0, data_byte});
                            n = 3'd1;
                            phase_next = PH_SOS_TAIL;
                        end
                        default: begin
                        end
                    endcase
                    if (!halted_next && remain_next == 16'd0)
                        phase_next = in_sos ? PH_SCAN : PH_HUNT;
                end
            endcase

            // marker dispatch; n is 0 here, slot 0 takes the marker
            if (dispatch) begin
                batch.ev[0] = mk_ev(EV_MARKER, 2'd0, 8'd0, {8'd0, data_byte});
                n = 3'd1;
                if (data_byte == M_SOI) begin
                    phase_next = PH_THUMB;
                end else if (data_byte == M_EOI || data_byte == M_TEM ||
                             (data_byte >= M_RST0 && data_byte <= M_RST7)) begin
                    phase_next = PH_HUNT;
                end else if (data_byte == M_SOF2) begin
                    batch.ev[1] = mk_ev(EV_ERROR, 2'd0, 8'd0, ERR_PROG);
                    n = 3'd2;
                    halted_next = 1'b1;
                end else begin
                    case (data_byte)
                        M_DRI:   tgt = PH_DRI_HI;
                        M_SOF0:  tgt = PH_SOF_P;
                        M_DQT:   tgt = PH_DQT_HDR;
                        M_DHT:   tgt = PH_DHT_HDR;
                        M_SOS:   tgt = PH_SOS_NS;
                        default: tgt = PH_SKIP;
                    endcase
                    fpos_next = {3'd0, tgt};
                    phase_next = PH_LEN_HI;
                end
            end
        end else begin
            pff_next = pff_reg;
        end

        if (final_byte) begin
            batch.ev[n[1:0]] = mk_ev(EV_END, 2'd0, 8'd0, 16'd0);
            n = n + 3'd1;
        end
        batch.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && final_byte)) begin
            phase_reg <= PH_FIRST;
            remain_reg <= '0;
            fpos_reg <= '0;
            hold_reg <= '0;
            table_reg <= '0;
            symtot_reg <= '0;
            restart_reg <= '0;
            ncomp_reg <= '0;
            maxh_reg <= '0;
            maxv_reg <= '0;
            pff_reg <= 1'b0;
            halted_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            remain_reg <= remain_next;
            fpos_reg <= fpos_next;
            hold_reg <= hold_next;
            table_reg <= table_next;
            symtot_reg <= symtot_next;
            restart_reg <= restart_next;
            ncomp_reg <= ncomp_next;
            maxh_reg <= maxh_next;
            maxv_reg <= maxv_next;
            pff_reg <= pff_next;
            halted_reg <= halted_next;
        end
    end

endmodule

@@ sv/jmsp_out.sv @@
module jmsp_out
    import jmsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  batch_t      batch,
    output logic        can_load,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_event_kind,
    output logic [1:0]  m_table_slot,
    output logic [7:0]  m_field_index,
    output logic [15:0] m_field_value,
    output logic        m_run_last
);

    batch_t     buf_reg;
    logic [2:0] ptr_reg;
    logic       full_reg;
    logic       last_one;

    assign last_one = (ptr_reg + 3'd1) == buf_reg.count;
    // a new batch may enter when the buffer is empty or its last event leaves now
    assign can_load = !full_reg || (m_ready && last_one);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            ptr_reg <= '0;
        end else if (load && can_load) begin
            full_reg <= batch.count != 3'd0;
            ptr_reg <= '0;
        end else if (full_reg && m_ready) begin
            ptr_reg <= ptr_reg + 3'd1;
            if (last_one) full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) buf_reg <= batch;
    end

    assign m_valid = full_reg;
    assign m_event_kind = buf_reg.ev[ptr_reg[1:0]].kind;
    assign m_table_slot = buf_reg.ev[ptr_reg[1:0]].slot;
    assign m_field_index = buf_reg.ev[ptr_reg[1:0]].idx;
    assign m_field_value = buf_reg.ev[ptr_reg[1:0]].value;
    assign m_run_last = last_one;

endmodule

@@ sv/jpeg_marker_segment_parser.sv @@
// channel | ports                                             | direction
// input   | s_valid s_ready s_data_byte s_final_byte          | byte in
// result  | m_valid m_ready m_event_kind m_table_slot         | event out
//         | m_field_index m_field_value m_run_last            |
// One byte is accepted per cycle while the output buffer can load; its events (up to four)
// leave it one per cycle unless m_ready stalls, and the next byte waits until the last one leaves.
// Parser state updates at the byte's acceptance; events appear the next cycle.
// Reset (aresetn low, synchronous) empties the buffer and returns to SOI search.
// A stall on m_ready holds the buffer and blocks input once it is full.
module jpeg_marker_segment_parser
    import jmsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_event_kind,
    output logic [1:0]  m_table_slot,
    output logic [7:0]  m_field_index,
    output logic [15:0] m_field_value,
    output logic        m_run_last
);

    batch_t batch;
    logic   can_load;
    logic   step;

    assign s_ready = can_load;
    assign step = s_valid && can_load;

    jmsp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .data_byte  (s_data_byte),
        .final_byte (s_final_byte),
        .batch      (batch)
    );

    jmsp_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (step),
        .batch         (batch),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_table_slot  (m_table_slot),
        .m_field_index (m_field_index),
        .m_field_value (m_field_value),
        .m_run_last    (m_run_last)
    );

endmodule

@@ sv/jmsp_checker.sv @@
module jmsp_checker
    import jmsp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_final_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_event_kind,
    input logic [1:0]  m_table_slot,
    input logic [7:0]  m_field_index,
    input logic [15:0] m_field_value,
    input logic        m_run_last
);

    // the final byte always yields at least its end event
    a_final_gives_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_final_byte |=> m_valid)
        else $error("final byte without event");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == EV_END |-> m_run_last)
        else $error("end event not last");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_kind <= EV_END)
        else $error("bad event kind");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_field_value) && $stable(m_event_kind)
            && $stable(m_table_slot) && $stable(m_field_index) && $stable(m_run_last))
        else $error("stalled event changed");

endmodule

bind jpeg_marker_segment_parser jmsp_checker u_jmsp_checker (.*);
